@@ src/wms_pkg.sv @@
// ----------------------------------------------------------------------------
// wms_pkg
// Shared constants, types and arithmetic for the weighted monotone
// subsequence block.
// ----------------------------------------------------------------------------
package wms_pkg;

  localparam int HEIGHTS         = 256;
  localparam int HEIGHT_BITS     = $clog2(HEIGHTS);
  localparam int IN_HEIGHT_BITS  = 8;
  localparam int IN_WIDTH_BITS   = 16;
  localparam int WIDTH_BITS      = 16;
  localparam int TOTAL_BITS      = 32;

  typedef logic [TOTAL_BITS-1:0]  total_t;
  typedef logic [HEIGHT_BITS-1:0] hidx_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic update;
    logic emit;
  } wms_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic last;
    logic out_free;
  } wms_sts_t;

  function automatic total_t sat_add(input total_t a, input total_t b);
    logic [TOTAL_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TOTAL_BITS] ? {TOTAL_BITS{1'b1}} : s[TOTAL_BITS-1:0];
  endfunction

  function automatic hidx_t clamp_height(input logic [IN_HEIGHT_BITS-1:0] x);
    if (32'(x) >= HEIGHTS) begin
      return HEIGHT_BITS'(HEIGHTS - 1);
    end
    return HEIGHT_BITS'(x);
  endfunction

endpackage

@@ src/wms_ctrl.sv @@
// ----------------------------------------------------------------------------
// wms_ctrl
// Sequencer: accepts one beat, runs the table scan, the update and, on the
// last beat of a case, the result hand-off.
// ----------------------------------------------------------------------------
module wms_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  wms_pkg::wms_sts_t sts,
  output wms_pkg::wms_cmd_t cmd
);
  import wms_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_FINISH = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_end) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = sts.last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/wms_dp.sv @@
// ----------------------------------------------------------------------------
// wms_dp
// Datapath: the two per-height tables, the scan maxima, the saturating
// update and the output register.
// ----------------------------------------------------------------------------
module wms_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [wms_pkg::IN_HEIGHT_BITS-1:0]   height,
  input  logic [wms_pkg::IN_WIDTH_BITS-1:0]    width,
  input  logic                                 last,
  input  wms_pkg::wms_cmd_t                    cmd,
  output wms_pkg::wms_sts_t                    sts,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [wms_pkg::TOTAL_BITS-1:0]       increasing_total,
  output logic [wms_pkg::TOTAL_BITS-1:0]       decreasing_total,
  output logic                                 increasing_not_less
);
  import wms_pkg::*;

  total_t rise_mem [HEIGHTS];
  total_t fall_mem [HEIGHTS];
  logic [HEIGHTS-1:0] vld;

  hidx_t                 h;
  logic [WIDTH_BITS-1:0] w;
  logic                  lst;
  hidx_t                 addr;
  hidx_t                 rd_idx;
  logic                  rd_act;
  logic                  rd_vld;
  total_t                rd_rise;
  total_t                rd_fall;
  total_t                below;
  total_t                above;
  total_t                cur_rise;
  total_t                cur_fall;
  total_t                rise_overall;
  total_t                fall_overall;

  total_t e_rise, e_fall, rise_sum, fall_sum, rise_wr, fall_wr;

  assign e_rise   = rd_vld ? rd_rise : '0;
  assign e_fall   = rd_vld ? rd_fall : '0;
  assign rise_sum = sat_add(below, TOTAL_BITS'(w));
  assign fall_sum = sat_add(above, TOTAL_BITS'(w));
  assign rise_wr  = (rise_sum > cur_rise) ? rise_sum : cur_rise;
  assign fall_wr  = (fall_sum > cur_fall) ? fall_sum : cur_fall;

  assign sts.scan_end = (addr == HEIGHT_BITS'(HEIGHTS - 1));
  assign sts.last     = lst;
  assign sts.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      rise_mem[h] <= rise_wr;
      fall_mem[h] <= fall_wr;
    end
    rd_rise <= rise_mem[addr];
    rd_fall <= fall_mem[addr];
    rd_vld  <= vld[addr];
    rd_idx  <= addr;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      vld <= '0;
    end else if (cmd.update) begin
      vld[h] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_act <= 1'b0;
    end else begin
      rd_act <= cmd.scan;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      h     <= clamp_height(height);
      w     <= width[WIDTH_BITS-1:0];
      lst   <= last;
      addr  <= '0;
      below <= '0;
      above <= '0;
    end else begin
      if (cmd.scan) begin
        addr <= addr + 1'b1;
      end
      if (rd_act) begin
        if (rd_idx < h && e_rise > below) begin
          below <= e_rise;
        end
        if (rd_idx > h && e_fall > above) begin
          above <= e_fall;
        end
        if (rd_idx == h) begin
          cur_rise <= e_rise;
          cur_fall <= e_fall;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      rise_overall <= '0;
      fall_overall <= '0;
    end else if (cmd.update) begin
      if (rise_sum > rise_overall) begin
        rise_overall <= rise_sum;
      end
      if (fall_sum > fall_overall) begin
        fall_overall <= fall_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      increasing_total    <= rise_overall;
      decreasing_total    <= fall_overall;
      increasing_not_less <= (rise_overall >= fall_overall);
    end
  end

endmodule

@@ src/weighted_monotone_subsequence_top.sv @@
// ----------------------------------------------------------------------------
// weighted_monotone_subsequence_top
// Best total width of a strictly rising and a strictly falling subsequence
// of heights, one result per case.
// ----------------------------------------------------------------------------
// The input channel carries one item per beat: height, width and last.
// Items with last low only update the two per-height tables and the case
// totals; the item with last high also closes the case and yields one result
// beat with both totals and the comparison flag.
// The time each item takes is set by the scan of the height tables, one entry
// per cycle through the single read port of each table.
// A closing item then passes through the emit state, which loads the output
// register once that register is free, and its result is then offered.
// The output register frees the datapath: while a result waits, the next
// item is accepted; only a second closing item waits for the first result.
// A stalled result holds its value until it is taken.
// Reset empties both tables and the case totals at once through per-entry
// valid bits; the block accepts an item in the first cycle after reset.
// The tables are emptied the same way after every closing item.
// ----------------------------------------------------------------------------
module weighted_monotone_subsequence_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [wms_pkg::IN_HEIGHT_BITS-1:0] height,
  input  logic [wms_pkg::IN_WIDTH_BITS-1:0]  width,
  input  logic                               last,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [wms_pkg::TOTAL_BITS-1:0]     increasing_total,
  output logic [wms_pkg::TOTAL_BITS-1:0]     decreasing_total,
  output logic                               increasing_not_less
);
  import wms_pkg::*;

  wms_cmd_t cmd;
  wms_sts_t sts;

  wms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  wms_dp u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .height              (height),
    .width               (width),
    .last                (last),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .increasing_total    (increasing_total),
    .decreasing_total    (decreasing_total),
    .increasing_not_less (increasing_not_less)
  );

endmodule

@@ tb/wms_checker.sv @@
// ----------------------------------------------------------------------------
// wms_checker
// Watches both channels of the weighted monotone subsequence block. It keeps
// its own per-height tables of best rising and falling totals, works out the
// totals that each closing beat must produce, and compares every result beat
// field by field with the oldest open case.
// ----------------------------------------------------------------------------
module wms_checker
  import wms_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [IN_HEIGHT_BITS-1:0] height,
  input  logic [IN_WIDTH_BITS-1:0]  width,
  input  logic                      last,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [TOTAL_BITS-1:0]     increasing_total,
  input  logic [TOTAL_BITS-1:0]     decreasing_total,
  input  logic                      increasing_not_less,
  output int                        mismatches,
  output int                        results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OPEN_DEPTH = 16;

  typedef struct packed {
    total_t rising;
    total_t falling;
    logic   rising_not_less;
  } case_totals_t;

  total_t       rise_end [HEIGHTS];
  total_t       fall_end [HEIGHTS];
  total_t       rise_case;
  total_t       fall_case;
  case_totals_t open_cases [OPEN_DEPTH];
  int           open_wr;
  int           open_rd;

  function automatic total_t capped_sum(input total_t a, input total_t b);
    logic [TOTAL_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TOTAL_BITS] ? '1 : s[TOTAL_BITS-1:0];
  endfunction

  task automatic clear_tables();
    int i;
    for (i = 0; i < HEIGHTS; i++) begin
      rise_end[i] = '0;
      fall_end[i] = '0;
    end
    rise_case = '0;
    fall_case = '0;
  endtask

  task automatic fold_item(input logic [IN_HEIGHT_BITS-1:0] h_in,
                           input logic [IN_WIDTH_BITS-1:0] w_in, input logic closes);
    int           hi;
    int           i;
    total_t       w;
    total_t       below;
    total_t       above;
    total_t       rise;
    total_t       fall;
    case_totals_t res;
    hi = (int'(h_in) >= HEIGHTS) ? HEIGHTS - 1 : int'(h_in);
    w = total_t'(w_in) & ((total_t'(1) << WIDTH_BITS) - 1);
    below = '0;
    above = '0;
    for (i = 0; i < HEIGHTS; i++) begin
      if (i < hi && rise_end[i] > below) below = rise_end[i];
      if (i > hi && fall_end[i] > above) above = fall_end[i];
    end
    rise = capped_sum(below, w);
    fall = capped_sum(above, w);
    if (rise > rise_end[hi]) rise_end[hi] = rise;
    if (fall > fall_end[hi]) fall_end[hi] = fall;
    if (rise > rise_case) rise_case = rise;
    if (fall > fall_case) fall_case = fall;
    if (closes) begin
      res.rising = rise_case;
      res.falling = fall_case;
      res.rising_not_less = (rise_case >= fall_case);
      open_cases[open_wr % OPEN_DEPTH] = res;
      open_wr++;
      clear_tables();
    end
  endtask

  always @(posedge clk) begin
    case_totals_t exp;
    logic         bad;
    bad = 1'b0;
    if (rst) begin
      clear_tables();
      open_wr = 0;
      open_rd = 0;
      mismatches <= 0;
      results_owed <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (open_wr == open_rd) begin
          $display("%0t: result beat with no open case: increasing %0d decreasing %0d flag %0b",
                   $time, increasing_total, decreasing_total, increasing_not_less);
          bad = 1'b1;
        end else begin
          exp = open_cases[open_rd % OPEN_DEPTH];
          open_rd++;
          if (increasing_total !== exp.rising) begin
            $display("%0t: increasing_total expected %0d actual %0d",
                     $time, exp.rising, increasing_total);
            bad = 1'b1;
          end
          if (decreasing_total !== exp.falling) begin
            $display("%0t: decreasing_total expected %0d actual %0d",
                     $time, exp.falling, decreasing_total);
            bad = 1'b1;
          end
          if (increasing_not_less !== exp.rising_not_less) begin
            $display("%0t: increasing_not_less expected %0b actual %0b",
                     $time, exp.rising_not_less, increasing_not_less);
            bad = 1'b1;
          end
        end
      end
      if (in_valid && !in_stall) fold_item(height, width, last);
      if (bad) mismatches <= mismatches + 1;
      results_owed <= open_wr - open_rd;
    end
  end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the weighted monotone subsequence block. A short
// directed set of cases is followed by random cases under several idling
// patterns, a long output hold-off that backs up the input, and a full drain.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES  = 3000;
  localparam int QUIET_LIMIT  = 20000;
  localparam int PHASE_ITEMS  = 400;

  logic                               clk;
  logic                               rst;
  logic                               in_valid;
  logic                               in_stall;
  logic [wms_pkg::IN_HEIGHT_BITS-1:0] height;
  logic [wms_pkg::IN_WIDTH_BITS-1:0]  width;
  logic                               last;
  logic                               out_valid;
  logic                               out_stall;
  logic [wms_pkg::TOTAL_BITS-1:0]     increasing_total;
  logic [wms_pkg::TOTAL_BITS-1:0]     decreasing_total;
  logic                               increasing_not_less;

  int mismatches;
  int results_owed;
  int send_idle_pct;
  int recv_stall_pct;
  int items_sent;
  int quiet;
  int stall_left;
  int hold_reqs;

  weighted_monotone_subsequence_top uut (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .height              (height),
    .width               (width),
    .last                (last),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .increasing_total    (increasing_total),
    .decreasing_total    (decreasing_total),
    .increasing_not_less (increasing_not_less)
  );

  wms_checker checker_i (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .height              (height),
    .width               (width),
    .last                (last),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .increasing_total    (increasing_total),
    .decreasing_total    (decreasing_total),
    .increasing_not_less (increasing_not_less),
    .mismatches          (mismatches),
    .results_owed        (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The receiver holds off for a long stretch when asked, else stalls at random.
  initial begin
    int holds_taken;
    out_stall <= 1'b0;
    stall_left = 0;
    holds_taken = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_taken) begin
        holds_taken = hold_reqs;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (int'($urandom_range(99)) < recv_stall_pct) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet == QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_item(input logic [7:0] h, input logic [15:0] w, input logic l);
    int gap;
    gap = 0;
    if (int'($urandom_range(99)) < send_idle_pct) begin
      gap = $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(1, 320);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    height <= h;
    width <= w;
    last <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_random_case(input int longest);
    int          n;
    int          k;
    int          shape;
    int          lo;
    int          h;
    logic [15:0] w;
    n = (int'($urandom_range(99)) < 5) ? $urandom_range(40, 120) : $urandom_range(1, longest);
    shape = $urandom_range(0, 3);
    lo = $urandom_range(0, 248);
    h = $urandom_range(0, 255);
    for (k = 0; k < n; k++) begin
      case (shape)
        0: begin
          if ($urandom_range(0, 7) == 0) h = $urandom_range(0, 1) ? 255 : 0;
          else h = $urandom_range(0, 255);
        end
        1: h = $urandom_range(lo, lo + 7);
        2: h = h + int'($urandom_range(0, 9)) - 3;
        default: h = h - int'($urandom_range(0, 9)) + 3;
      endcase
      if (h < 0) h = 0;
      if (h > 255) h = 255;
      case ($urandom_range(0, 3))
        0: w = 16'($urandom_range(0, 3));
        1: w = 16'hFFFF - 16'($urandom_range(0, 3));
        default: w = 16'($urandom_range(0, 65535));
      endcase
      send_item(8'(h), w, k == n - 1);
    end
  endtask

  task automatic wait_drained();
    @(posedge clk);
    wait (results_owed == 0);
    @(posedge clk);
  endtask

  initial begin
    int phase;
    int k;
    rst <= 1'b1;
    in_valid <= 1'b0;
    height <= '0;
    width <= '0;
    last <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    items_sent = 0;
    hold_reqs = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Smallest and largest single-item cases.
    send_item(8'd0, 16'h0000, 1'b1);
    send_item(8'd255, 16'hFFFF, 1'b1);
    // A strictly rising run ending at the top height.
    send_item(8'd0, 16'd1, 1'b0);
    send_item(8'd10, 16'd2, 1'b0);
    send_item(8'd20, 16'd3, 1'b0);
    send_item(8'd255, 16'd4, 1'b1);
    // A strictly falling run down to height zero, so falling wins.
    send_item(8'd255, 16'd100, 1'b0);
    send_item(8'd128, 16'd100, 1'b0);
    send_item(8'd0, 16'd100, 1'b1);
    // Equal heights never chain in either direction.
    send_item(8'd7, 16'd5, 1'b0);
    send_item(8'd7, 16'd5, 1'b0);
    send_item(8'd7, 16'd5, 1'b1);
    // Alternating bit patterns in the width.
    send_item(8'd5, 16'hAAAA, 1'b0);
    send_item(8'd3, 16'h5555, 1'b0);
    send_item(8'd9, 16'hFFFF, 1'b0);
    send_item(8'd1, 16'h0001, 1'b1);
    // Zero widths give zero totals.
    send_item(8'd100, 16'd0, 1'b0);
    send_item(8'd50, 16'd0, 1'b1);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      k = items_sent + PHASE_ITEMS;
      while (items_sent < k) send_random_case(30);
      if (phase == 0) begin
        // Hold the output off while short cases pile up behind it.
        hold_reqs++;
        for (k = 0; k < 8; k++) send_random_case(2);
        in_valid <= 1'b0;
        wait_drained();
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ weighted_monotone_subsequence_top.f @@
src/wms_pkg.sv
src/wms_ctrl.sv
src/wms_dp.sv
src/weighted_monotone_subsequence_top.sv
tb/wms_checker.sv
tb/tb_top.sv
